FILE: rtl/i128_pkg.sv
// ----------------------------------------------------------------------------
// i128_pkg: shared types and codes of the 128-bit integer ALU.
// Holds the op codes, the input and result payload structs and the stage
// control struct that travels through the multiplier pipeline.
// ----------------------------------------------------------------------------
package i128_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned WordW  = 128;
  localparam int unsigned OpW    = 5;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned LimbW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_NEG    = 5'd2,
    OP_NOT    = 5'd3,
    OP_AND    = 5'd4,
    OP_OR     = 5'd5,
    OP_XOR    = 5'd6,
    OP_SHL    = 5'd7,
    OP_SHR    = 5'd8,
    OP_SAR    = 5'd9,
    OP_MULLO  = 5'd10,
    OP_MULHI  = 5'd11,
    OP_EQ     = 5'd12,
    OP_NE     = 5'd13,
    OP_GT     = 5'd14,
    OP_LE     = 5'd15,
    OP_LT     = 5'd16,
    OP_GE     = 5'd17,
    OP_UGT    = 5'd18,
    OP_ULE    = 5'd19,
    OP_ULT    = 5'd20,
    OP_UGE    = 5'd21,
    OP_ZERO   = 5'd22,
    OP_FITS64 = 5'd23
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [HalfW-1:0]  a_lo;
    logic [HalfW-1:0]  a_hi;
    logic [HalfW-1:0]  b_lo;
    logic [HalfW-1:0]  b_hi;
    logic [ShiftW-1:0] shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] result_lo;
    logic [HalfW-1:0] result_hi;
    logic             flag;
  } out_item_t;

  // Side band that rides alongside the product through the multiplier.
  typedef struct packed {
    logic             is_mul;
    logic             take_hi;
    logic [WordW-1:0] alt_res;
    logic             alt_flag;
  } side_t;

endpackage

FILE: rtl/i128_mul.sv
// ----------------------------------------------------------------------------
// i128_mul: pipelined 128 x 128 unsigned multiplier.
// Sixteen 32x32 partial products are registered, summed per weight column,
// then folded into the full 256-bit product. Side data travels with each
// item; the whole pipe advances on a common enable.
// ----------------------------------------------------------------------------
module i128_mul
  import i128_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [WordW-1:0]       a,
  input  logic [WordW-1:0]       b,
  input  i128_pkg::side_t        in_side,
  output logic                   out_valid,
  output logic [2*WordW-1:0]     product,
  output i128_pkg::side_t        out_side
);

  localparam int unsigned NLimb = WordW / LimbW;
  localparam int unsigned NCol  = 2 * NLimb - 1;
  localparam int unsigned ColW  = 2 * LimbW + 2;

  logic [2*LimbW-1:0] pp [NLimb][NLimb];
  logic [ColW-1:0]    col [NCol];
  logic [ColW-1:0]    col_next [NCol];
  logic [2:0]         vld;
  side_t              side1, side2;

  // Stage 1: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLimb; i++) begin
        for (int j = 0; j < NLimb; j++) begin
          pp[i][j] <= a[i*LimbW +: LimbW] * b[j*LimbW +: LimbW];
        end
      end
      side1 <= in_side;
    end
  end

  // Stage 2: sum partial products of equal weight.
  always_comb begin
    for (int k = 0; k < NCol; k++) begin
      col_next[k] = '0;
      for (int i = 0; i < NLimb; i++) begin
        for (int j = 0; j < NLimb; j++) begin
          if (i + j == k) begin
            col_next[k] = col_next[k] + ColW'(pp[i][j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col   <= col_next;
      side2 <= side1;
    end
  end

  // Stage 3: fold the weighted columns into the product.
  always_ff @(posedge clk) begin
    if (en) begin
      logic [2*WordW-1:0] acc;
      acc = '0;
      for (int k = 0; k < NCol; k++) begin
        acc = acc + ((2*WordW)'(col[k]) << (k * LimbW));
      end
      product  <= acc;
      out_side <= side2;
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  assign out_valid = vld[2];

endmodule

FILE: rtl/int128_alu.sv
// ----------------------------------------------------------------------------
// int128_alu: 128-bit integer ALU top level.
// Add, subtract, logic, shifts, multiplies and compares on 128-bit operands.
// ----------------------------------------------------------------------------
// One operation is accepted every cycle while the pipe is not stalled. Every
// item passes four register stages: the partial products (the non-multiply
// result is computed beside them in the same cycle), the column sums, the
// final fold, and the output register. The pipe stalls as a whole only
// while the output register holds a result not yet taken.
module int128_alu
  import i128_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i128_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i128_pkg::out_item_t   out_data
);

  logic [WordW-1:0]   a, b, sum, dif, neg, shl, shr;
  logic [WordW-1:0]   alt;
  logic               f, eq, sgt, slt, ugt, ult;
  logic [WordW-1:0]   sx;
  side_t              side;
  logic               en, mvalid;
  logic [2*WordW-1:0] prod;
  side_t              mside;

  assign a = {in_data.a_hi, in_data.a_lo};
  assign b = {in_data.b_hi, in_data.b_lo};

  // Advance whenever the output register is free or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Non-multiply results. The fill word covers the whole operand so that
  // an arithmetic shift by any amount brings in sign bits only.
  always_comb begin
    sum = a + b;
    dif = a - b;
    neg = -a;
    shl = a << in_data.shift_amount;
    sx  = (in_data.op == OP_SAR && a[WordW-1]) ? '1 : '0;
    shr = WordW'({sx, a} >> in_data.shift_amount);
    eq  = (a == b);
    ugt = (a > b);
    ult = (a < b);
    sgt = ($signed(a) > $signed(b));
    slt = ($signed(a) < $signed(b));
    alt = '0;
    f   = 1'b0;
    unique case (in_data.op) inside
      OP_ADD:   alt = sum;
      OP_SUB:   alt = dif;
      OP_NEG:   alt = neg;
      OP_NOT:   alt = ~a;
      OP_AND:   alt = a & b;
      OP_OR:    alt = a | b;
      OP_XOR:   alt = a ^ b;
      OP_SHL:   alt = shl;
      OP_SHR, OP_SAR: alt = shr;
      OP_EQ:    f = eq;
      OP_NE:    f = !eq;
      OP_GT:    f = sgt;
      OP_LE:    f = !sgt;
      OP_LT:    f = slt;
      OP_GE:    f = !slt;
      OP_UGT:   f = ugt;
      OP_ULE:   f = !ugt;
      OP_ULT:   f = ult;
      OP_UGE:   f = !ult;
      OP_ZERO:  f = (a == '0);
      OP_FITS64: f = (in_data.a_hi == {HalfW{in_data.a_lo[HalfW-1]}});
      default:  alt = '0;
    endcase
    side.is_mul   = (in_data.op == OP_MULLO) || (in_data.op == OP_MULHI);
    side.take_hi  = (in_data.op == OP_MULHI);
    side.alt_res  = alt;
    side.alt_flag = f;
  end

  i128_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (a),
    .b         (b),
    .in_side   (side),
    .out_valid (mvalid),
    .product   (prod),
    .out_side  (mside)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (mside.is_mul) begin
        {out_data.result_hi, out_data.result_lo} <=
          mside.take_hi ? prod[2*WordW-1:WordW] : prod[WordW-1:0];
      end else begin
        {out_data.result_hi, out_data.result_lo} <= mside.alt_res;
      end
      out_data.flag <= mside.alt_flag;
    end
  end

endmodule
